// ----- hw/rtl/wsd_pkg.sv -----
package wsd_pkg;

  localparam int RX_W       = 8;
  localparam int MAXP_W     = 31;
  localparam int KIND_W     = 3;
  localparam int ERR_W      = 4;
  localparam int LEN_W      = 64;
  localparam int MSG_W      = 32;

  localparam logic [MAXP_W-1:0] MAX_PAYLOAD_RST = 31'd1048576;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_TEXT   = 3'd0;
  localparam logic [KIND_W-1:0] KIND_BINARY = 3'd1;
  localparam logic [KIND_W-1:0] KIND_PING   = 3'd2;
  localparam logic [KIND_W-1:0] KIND_CLOSE  = 3'd3;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 3'd4;

  // Error codes
  localparam logic [ERR_W-1:0] ERR_NONE       = 4'd0;
  localparam logic [ERR_W-1:0] ERR_RSV        = 4'd1;
  localparam logic [ERR_W-1:0] ERR_MASKED     = 4'd2;
  localparam logic [ERR_W-1:0] ERR_SHORT16    = 4'd3;
  localparam logic [ERR_W-1:0] ERR_LEN_MSB    = 4'd4;
  localparam logic [ERR_W-1:0] ERR_SHORT64    = 4'd5;
  localparam logic [ERR_W-1:0] ERR_TOO_BIG    = 4'd6;
  localparam logic [ERR_W-1:0] ERR_BAD_CTRL   = 4'd7;
  localparam logic [ERR_W-1:0] ERR_CLOSE_LEN1 = 4'd8;
  localparam logic [ERR_W-1:0] ERR_BAD_OP     = 4'd9;
  localparam logic [ERR_W-1:0] ERR_DATA_FRAG  = 4'd10;
  localparam logic [ERR_W-1:0] ERR_CONT_SEQ   = 4'd11;

  // Frame opcodes
  localparam logic [3:0] OP_CONT   = 4'h0;
  localparam logic [3:0] OP_TEXT   = 4'h1;
  localparam logic [3:0] OP_BINARY = 4'h2;
  localparam logic [3:0] OP_CLOSE  = 4'h8;
  localparam logic [3:0] OP_PING   = 4'h9;
  localparam logic [3:0] OP_PONG   = 4'hA;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic              has_byte;
    logic [RX_W-1:0]   payload_byte;
    logic              end_of_message;
    logic [ERR_W-1:0]  error_code;
  } wsd_result_t;

endpackage

// ----- hw/rtl/wsd_rx_if.sv -----
interface wsd_rx_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface

// ----- hw/rtl/wsd_evt_if.sv -----
interface wsd_evt_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic       has_byte;
  logic [7:0] payload_byte;
  logic       end_of_message;
  logic [3:0] error_code;

  modport source (output valid, output kind, output has_byte, output payload_byte,
                  output end_of_message, output error_code, input ready);
  modport sink (input valid, input kind, input has_byte, input payload_byte,
                input end_of_message, input error_code, output ready);
endinterface

// ----- hw/rtl/wsd_parse.sv -----
module wsd_parse (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      accept,
  input  logic [7:0]                rx_byte,
  input  logic                      cfg_we,
  input  logic [30:0]               cfg_wdata,
  output logic                      res_valid,
  output wsd_pkg::wsd_result_t      res
);
  import wsd_pkg::*;

  localparam logic [1:0] PH_B0  = 2'd0;
  localparam logic [1:0] PH_B1  = 2'd1;
  localparam logic [1:0] PH_EXT = 2'd2;
  localparam logic [1:0] PH_PAY = 2'd3;

  logic [MAXP_W-1:0] max_payload;
  logic [1:0]        phase, phase_next;
  logic [3:0]        frame_opcode, frame_opcode_next;
  logic              frame_fin, frame_fin_next;
  logic              rsv_set, rsv_set_next;
  logic              long_form, long_form_next;
  logic [3:0]        ext_bytes_left, ext_bytes_left_next;
  logic [LEN_W-1:0]  length_shift, length_shift_next;
  logic [MAXP_W-1:0] payload_left, payload_left_next;
  logic [1:0]        fragment_kind, fragment_kind_next;
  logic [MSG_W-1:0]  message_length, message_length_next;
  logic              halted, halted_next;

  logic              hdr_go;
  logic [LEN_W-1:0]  hdr_len;
  logic [MSG_W:0]    msg_sum;
  logic              len_big, len_nz, len_gt125, len_eq1, msg_big, op_known;
  logic              fail_v;
  logic [ERR_W-1:0]  fail_code;
  logic [LEN_W-1:0]  ext_len;
  logic [MAXP_W-1:0] left_dec;

  assign ext_len  = {length_shift[LEN_W-9:0], rx_byte};
  assign left_dec = payload_left - 31'd1;
  assign hdr_len  = (phase == PH_EXT) ? ext_len : {57'd0, rx_byte[6:0]};
  assign msg_sum  = {1'b0, message_length} + {2'b00, hdr_len[30:0]};
  assign len_big  = (|hdr_len[63:31]) || (hdr_len[30:0] > max_payload);
  assign len_nz   = |hdr_len;
  assign len_gt125 = (|hdr_len[63:7]) || (hdr_len[6:0] > 7'd125);
  assign len_eq1  = (hdr_len == 64'd1);
  assign msg_big  = len_nz && (msg_sum > {2'b00, max_payload});
  assign op_known = (frame_opcode == OP_CONT) || (frame_opcode == OP_TEXT) ||
                    (frame_opcode == OP_BINARY) || (frame_opcode == OP_CLOSE) ||
                    (frame_opcode == OP_PING) || (frame_opcode == OP_PONG);

  always_comb begin
    phase_next          = phase;
    frame_opcode_next   = frame_opcode;
    frame_fin_next      = frame_fin;
    rsv_set_next        = rsv_set;
    long_form_next      = long_form;
    ext_bytes_left_next = ext_bytes_left;
    length_shift_next   = length_shift;
    payload_left_next   = payload_left;
    fragment_kind_next  = fragment_kind;
    message_length_next = message_length;
    halted_next         = halted;
    hdr_go              = 1'b0;
    fail_v              = 1'b0;
    fail_code           = ERR_NONE;
    res_valid           = 1'b0;
    res                 = '0;

    if (!halted) begin
      unique case (phase)
        PH_B0: begin
          frame_opcode_next = rx_byte[3:0];
          frame_fin_next    = rx_byte[7];
          rsv_set_next      = |rx_byte[6:4];
          phase_next        = PH_B1;
        end
        PH_B1: begin
          if (rsv_set) begin
            fail_v    = 1'b1;
            fail_code = ERR_RSV;
          end else if (rx_byte[7]) begin
            fail_v    = 1'b1;
            fail_code = ERR_MASKED;
          end else if (rx_byte[6:0] <= 7'd125) begin
            hdr_go = 1'b1;
          end else begin
            long_form_next      = (rx_byte[6:0] == 7'd127);
            ext_bytes_left_next = (rx_byte[6:0] == 7'd127) ? 4'd8 : 4'd2;
            length_shift_next   = '0;
            phase_next          = PH_EXT;
          end
        end
        PH_EXT: begin
          length_shift_next   = ext_len;
          ext_bytes_left_next = ext_bytes_left - 4'd1;
          if (ext_bytes_left == 4'd1) begin
            if (!long_form) begin
              if (ext_len < 64'd126) begin
                fail_v    = 1'b1;
                fail_code = ERR_SHORT16;
              end else begin
                hdr_go = 1'b1;
              end
            end else if (ext_len[63]) begin
              fail_v    = 1'b1;
              fail_code = ERR_LEN_MSB;
            end else if (ext_len < 64'd65536) begin
              fail_v    = 1'b1;
              fail_code = ERR_SHORT64;
            end else begin
              hdr_go = 1'b1;
            end
          end
        end
        PH_PAY: begin
          if (payload_left == '0) begin
            phase_next = PH_B0;
          end else begin
            payload_left_next = left_dec;
            if (left_dec == '0) begin
              phase_next = PH_B0;
            end
            res.has_byte     = 1'b1;
            res.payload_byte = rx_byte;
            if ((frame_opcode == OP_TEXT) || (frame_opcode == OP_BINARY)) begin
              res_valid          = 1'b1;
              res.kind           = KIND_W'(frame_opcode - 4'd1);
              res.end_of_message = (left_dec == '0) && frame_fin;
            end else if (frame_opcode == OP_CONT) begin
              res_valid          = 1'b1;
              res.kind           = KIND_W'(fragment_kind - 2'd1);
              res.end_of_message = (left_dec == '0) && frame_fin;
              if ((left_dec == '0) && frame_fin) begin
                fragment_kind_next  = '0;
                message_length_next = '0;
              end
            end else if (frame_opcode == OP_PING) begin
              res_valid          = 1'b1;
              res.kind           = KIND_PING;
              res.end_of_message = (left_dec == '0);
            end else if ((frame_opcode == OP_CLOSE) && (left_dec == '0)) begin
              res_valid          = 1'b1;
              res.kind           = KIND_CLOSE;
              res.has_byte       = 1'b0;
              res.payload_byte   = '0;
              res.end_of_message = 1'b1;
              halted_next        = 1'b1;
            end else begin
              res.has_byte     = 1'b0;
              res.payload_byte = '0;
            end
          end
        end
        default: phase_next = PH_B0;
      endcase

      if (hdr_go) begin
        if (len_big) begin
          fail_v    = 1'b1;
          fail_code = ERR_TOO_BIG;
        end else if (frame_opcode[3] && (!frame_fin || len_gt125)) begin
          fail_v    = 1'b1;
          fail_code = ERR_BAD_CTRL;
        end else if ((frame_opcode == OP_CLOSE) && len_eq1) begin
          fail_v    = 1'b1;
          fail_code = ERR_CLOSE_LEN1;
        end else if (!op_known) begin
          fail_v    = 1'b1;
          fail_code = ERR_BAD_OP;
        end else if (((frame_opcode == OP_TEXT) || (frame_opcode == OP_BINARY)) &&
                     (fragment_kind != 2'd0)) begin
          fail_v    = 1'b1;
          fail_code = ERR_DATA_FRAG;
        end else if (((frame_opcode == OP_TEXT) || (frame_opcode == OP_BINARY)) &&
                     !frame_fin && msg_big) begin
          fail_v    = 1'b1;
          fail_code = ERR_CONT_SEQ;
        end else if ((frame_opcode == OP_CONT) &&
                     ((fragment_kind == 2'd0) || msg_big)) begin
          fail_v    = 1'b1;
          fail_code = ERR_CONT_SEQ;
        end else begin
          if (((frame_opcode == OP_TEXT) || (frame_opcode == OP_BINARY)) && !frame_fin) begin
            fragment_kind_next  = frame_opcode[1:0];
            message_length_next = msg_sum[MSG_W-1:0];
          end else if (frame_opcode == OP_CONT) begin
            message_length_next = msg_sum[MSG_W-1:0];
          end
          if (len_nz) begin
            payload_left_next = hdr_len[30:0];
            phase_next        = PH_PAY;
          end else begin
            phase_next = PH_B0;
            if ((frame_opcode == OP_TEXT) || (frame_opcode == OP_BINARY)) begin
              res_valid          = frame_fin;
              res.kind           = KIND_W'(frame_opcode - 4'd1);
              res.end_of_message = 1'b1;
            end else if (frame_opcode == OP_CONT) begin
              if (frame_fin) begin
                res_valid           = 1'b1;
                res.kind            = KIND_W'(fragment_kind - 2'd1);
                res.end_of_message  = 1'b1;
                fragment_kind_next  = '0;
                message_length_next = '0;
              end
            end else if (frame_opcode == OP_CLOSE) begin
              res_valid          = 1'b1;
              res.kind           = KIND_CLOSE;
              res.end_of_message = 1'b1;
              halted_next        = 1'b1;
            end else if (frame_opcode == OP_PING) begin
              res_valid          = 1'b1;
              res.kind           = KIND_PING;
              res.end_of_message = 1'b1;
            end
          end
        end
      end

      if (fail_v) begin
        halted_next = 1'b1;
        phase_next  = PH_B0;
        res_valid   = 1'b1;
        res         = '0;
        res.kind    = KIND_ERROR;
        res.error_code = fail_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload    <= MAX_PAYLOAD_RST;
      phase          <= PH_B0;
      frame_opcode   <= '0;
      frame_fin      <= 1'b0;
      rsv_set        <= 1'b0;
      long_form      <= 1'b0;
      ext_bytes_left <= '0;
      length_shift   <= '0;
      payload_left   <= '0;
      fragment_kind  <= '0;
      message_length <= '0;
      halted         <= 1'b0;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_wdata;
      end
      if (accept) begin
        phase          <= phase_next;
        frame_opcode   <= frame_opcode_next;
        frame_fin      <= frame_fin_next;
        rsv_set        <= rsv_set_next;
        long_form      <= long_form_next;
        ext_bytes_left <= ext_bytes_left_next;
        length_shift   <= length_shift_next;
        payload_left   <= payload_left_next;
        fragment_kind  <= fragment_kind_next;
        message_length <= message_length_next;
        halted         <= halted_next;
      end
    end
  end
endmodule

// ----- hw/rtl/wsd_outbuf.sv -----
module wsd_outbuf (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 push,
  input  wsd_pkg::wsd_result_t push_data,
  output logic                 has_room,
  output logic                 pop_valid,
  input  logic                 pop_ready,
  output wsd_pkg::wsd_result_t pop_data
);
  import wsd_pkg::*;

  wsd_result_t slots [2];
  logic        wr_ptr;
  logic        rd_ptr;
  logic [1:0]  count;
  logic        pop;

  assign has_room  = (count != 2'd2);
  assign pop_valid = (count != 2'd0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end
endmodule

// ----- hw/rtl/websocket_frame_deframer.sv -----
// Client-side WebSocket frame deframer for server-to-client traffic.
// The rx channel takes one received byte per transaction, one transaction
// per clock at best. Each byte is parsed in the cycle it is taken, and any
// result it causes enters a two-entry output queue, which registers it for
// the evt channel. Payload bytes of text, binary, continuation and ping
// frames are passed on as they arrive; pong payload is dropped and a close
// frame gives one close event at its end. Header errors are reported by the
// end of the header. After an error or a close event the block ignores all
// further bytes until reset. The block sustains one byte per cycle while
// evt is taken; the rate is set by the per-byte parse logic and the output
// queue. When the receiver stalls, rx stays ready until the queue holds two
// results, then waits for a slot. Reset (rst, synchronous) empties the
// queue, returns the parser to the start of a frame and sets max_payload to
// 1048576 bytes. max_payload is written through cfg_we and cfg_wdata; the
// user must write it only while the block is idle; this is not enforced.
module websocket_frame_deframer (
  input  logic                       clk,
  input  logic                       rst,
  wsd_rx_if.sink                     rx,
  wsd_evt_if.source                  evt,
  input  logic                       cfg_we,
  input  logic [wsd_pkg::MAXP_W-1:0] cfg_wdata
);
  import wsd_pkg::*;

  logic        accept;
  logic        has_room;
  logic        res_valid;
  wsd_result_t res;
  wsd_result_t head;

  assign rx.ready = has_room;
  assign accept   = rx.valid && has_room;

  wsd_parse u_parse (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .rx_byte   (rx.rx_byte),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .res_valid (res_valid),
    .res       (res)
  );

  wsd_outbuf u_outbuf (
    .clk       (clk),
    .rst       (rst),
    .push      (accept && res_valid),
    .push_data (res),
    .has_room  (has_room),
    .pop_valid (evt.valid),
    .pop_ready (evt.ready),
    .pop_data  (head)
  );

  assign evt.kind           = head.kind;
  assign evt.has_byte       = head.has_byte;
  assign evt.payload_byte   = head.payload_byte;
  assign evt.end_of_message = head.end_of_message;
  assign evt.error_code     = head.error_code;
endmodule

// ----- verif/websocket_frame_deframer_tb.sv -----
`timescale 1ns / 1ps

module websocket_frame_deframer_tb;
  import wsd_pkg::*;

  localparam logic [7:0] LEN16_MARK = 8'd126;
  localparam logic [7:0] LEN64_MARK = 8'd127;
  localparam int unsigned CTRL_MAX_LEN = 125;
  localparam int unsigned LONG_HOLD = 200;
  localparam int unsigned ITEMS_PER_SETTING = 70;

  typedef enum logic [1:0] {AT_HDR0, AT_HDR1, AT_EXT_LEN, AT_PAYLOAD} parse_phase_e;

  typedef enum int {
    END_RSV, END_MASKED, END_SHORT16, END_LEN_MSB, END_SHORT64, END_TOO_BIG, END_BAD_CTRL,
    END_CLOSE_LEN1, END_BAD_OP, END_DATA_FRAG, END_CONT_ALONE, END_MSG_TOO_BIG,
    END_CLOSE_PAYLOAD, END_CLOSE_EMPTY, END_NOISE
  } closing_case_e;

  class frame_scoreboard;
    logic [MAXP_W-1:0] max_payload;
    wsd_result_t pending_results[$];
    int mismatches;
    int results_checked;
    int kind_count[5];
    bit halted;
    parse_phase_e phase;
    logic [3:0] cur_op;
    logic cur_fin;
    logic [2:0] rsv_bits;
    logic [3:0] ext_left;
    bit long_len;
    logic [LEN_W-1:0] len_acc;
    logic [MAXP_W-1:0] pay_left;
    bit in_fragment;
    logic [KIND_W-1:0] frag_kind;
    logic [MSG_W-1:0] msg_len;

    function new();
      max_payload = MAX_PAYLOAD_RST;
      halted = 1'b0;
      phase = AT_HDR0;
      cur_op = OP_CONT;
      cur_fin = 1'b0;
      rsv_bits = '0;
      ext_left = '0;
      long_len = 1'b0;
      len_acc = '0;
      pay_left = '0;
      in_fragment = 1'b0;
      frag_kind = KIND_TEXT;
      msg_len = '0;
    endfunction

    function logic [KIND_W-1:0] kind_of(logic [3:0] op);
      return (op == OP_TEXT) ? KIND_TEXT : KIND_BINARY;
    endfunction

    function void expect_result(logic [KIND_W-1:0] kind, logic has, logic [7:0] data,
                                logic eom, logic [ERR_W-1:0] code);
      wsd_result_t r;
      r.kind = kind;
      r.has_byte = has;
      r.payload_byte = has ? data : 8'h00;
      r.end_of_message = eom;
      r.error_code = code;
      pending_results.push_back(r);
    endfunction

    function void raise_error(logic [ERR_W-1:0] code);
      halted = 1'b1;
      phase = AT_HDR0;
      expect_result(KIND_ERROR, 1'b0, 8'h00, 1'b0, code);
    endfunction

    function void end_of_header(logic [LEN_W-1:0] len);
      logic [LEN_W-1:0] total;
      if (len > max_payload) begin
        raise_error(ERR_TOO_BIG);
        return;
      end
      if (cur_op >= OP_CLOSE) begin
        if (!cur_fin || len > CTRL_MAX_LEN) begin
          raise_error(ERR_BAD_CTRL);
          return;
        end
        if (cur_op == OP_CLOSE && len == 1) begin
          raise_error(ERR_CLOSE_LEN1);
          return;
        end
      end
      if (!(cur_op <= OP_BINARY || cur_op == OP_CLOSE || cur_op == OP_PING
            || cur_op == OP_PONG)) begin
        raise_error(ERR_BAD_OP);
        return;
      end
      total = {32'd0, msg_len} + len;
      if (cur_op == OP_TEXT || cur_op == OP_BINARY) begin
        if (in_fragment) begin
          raise_error(ERR_DATA_FRAG);
          return;
        end
        if (!cur_fin) begin
          if (len != 0 && total > max_payload) begin
            raise_error(ERR_CONT_SEQ);
            return;
          end
          in_fragment = 1'b1;
          frag_kind = kind_of(cur_op);
          msg_len = total[MSG_W-1:0];
        end
      end else if (cur_op == OP_CONT) begin
        if (!in_fragment || (len != 0 && total > max_payload)) begin
          raise_error(ERR_CONT_SEQ);
          return;
        end
        msg_len = total[MSG_W-1:0];
      end
      if (len != 0) begin
        pay_left = len[MAXP_W-1:0];
        phase = AT_PAYLOAD;
        return;
      end
      phase = AT_HDR0;
      case (cur_op)
        OP_TEXT, OP_BINARY: begin
          if (cur_fin) expect_result(kind_of(cur_op), 1'b0, 8'h00, 1'b1, ERR_NONE);
        end
        OP_CONT: begin
          if (cur_fin) begin
            expect_result(frag_kind, 1'b0, 8'h00, 1'b1, ERR_NONE);
            in_fragment = 1'b0;
            msg_len = '0;
          end
        end
        OP_CLOSE: begin
          halted = 1'b1;
          expect_result(KIND_CLOSE, 1'b0, 8'h00, 1'b1, ERR_NONE);
        end
        OP_PING: expect_result(KIND_PING, 1'b0, 8'h00, 1'b1, ERR_NONE);
        default: ;
      endcase
    endfunction

    function void payload_in(logic [7:0] b);
      logic last;
      pay_left = pay_left - 1'b1;
      last = (pay_left == 0);
      if (last) phase = AT_HDR0;
      case (cur_op)
        OP_TEXT, OP_BINARY:
          expect_result(kind_of(cur_op), 1'b1, b, last && cur_fin, ERR_NONE);
        OP_CONT: begin
          expect_result(frag_kind, 1'b1, b, last && cur_fin, ERR_NONE);
          if (last && cur_fin) begin
            in_fragment = 1'b0;
            msg_len = '0;
          end
        end
        OP_PING: expect_result(KIND_PING, 1'b1, b, last, ERR_NONE);
        OP_CLOSE: begin
          if (last) begin
            halted = 1'b1;
            expect_result(KIND_CLOSE, 1'b0, 8'h00, 1'b1, ERR_NONE);
          end
        end
        default: ;
      endcase
    endfunction

    function void note_byte(logic [7:0] b);
      if (halted) return;
      case (phase)
        AT_HDR0: begin
          cur_op = b[3:0];
          cur_fin = b[7];
          rsv_bits = b[6:4];
          phase = AT_HDR1;
        end
        AT_HDR1: begin
          if (rsv_bits != 0) raise_error(ERR_RSV);
          else if (b[7]) raise_error(ERR_MASKED);
          else if (b[6:0] < LEN16_MARK[6:0]) end_of_header({57'd0, b[6:0]});
          else begin
            long_len = (b[6:0] == LEN64_MARK[6:0]);
            ext_left = long_len ? 4'd8 : 4'd2;
            len_acc = '0;
            phase = AT_EXT_LEN;
          end
        end
        AT_EXT_LEN: begin
          len_acc = {len_acc[LEN_W-9:0], b};
          ext_left = ext_left - 1'b1;
          if (ext_left == 0) begin
            if (!long_len) begin
              if (len_acc < LEN16_MARK) raise_error(ERR_SHORT16);
              else end_of_header(len_acc);
            end else if (len_acc[LEN_W-1]) raise_error(ERR_LEN_MSB);
            else if (len_acc < 65536) raise_error(ERR_SHORT64);
            else end_of_header(len_acc);
          end
        end
        default: payload_in(b);
      endcase
    endfunction

    task report_mismatch(input string msg);
      mismatches++;
      if (mismatches <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
    endtask

    function string show(wsd_result_t r);
      return $sformatf("kind %0d has_byte %0d byte %02h eom %0d error %0d",
                       r.kind, r.has_byte, r.payload_byte, r.end_of_message, r.error_code);
    endfunction

    task check_result(input wsd_result_t got);
      wsd_result_t want;
      if (got.kind <= KIND_ERROR) kind_count[got.kind]++;
      if (pending_results.size() == 0) begin
        report_mismatch({"result with nothing expected: ", show(got)});
        return;
      end
      want = pending_results.pop_front();
      results_checked++;
      if (got.kind !== want.kind)
        report_mismatch($sformatf("kind %0d, expected %0d", got.kind, want.kind));
      if (got.has_byte !== want.has_byte)
        report_mismatch($sformatf("has_byte %0d, expected %0d", got.has_byte, want.has_byte));
      if (got.payload_byte !== want.payload_byte)
        report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                  got.payload_byte, want.payload_byte));
      if (got.end_of_message !== want.end_of_message)
        report_mismatch($sformatf("end_of_message %0d, expected %0d",
                                  got.end_of_message, want.end_of_message));
      if (got.error_code !== want.error_code)
        report_mismatch($sformatf("error_code %0d, expected %0d",
                                  got.error_code, want.error_code));
    endtask

    task drain_check();
      if (pending_results.size() != 0) begin
        report_mismatch($sformatf("%0d expected results never arrived, oldest: %s",
                                  pending_results.size(), show(pending_results[0])));
        pending_results.delete();
      end
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [MAXP_W-1:0] cfg_wdata;

  wsd_rx_if rx_ch();
  wsd_evt_if evt_ch();

  frame_scoreboard sb = new();
  bit gaps_on = 1'b1;
  bit hold_request = 1'b0;
  int unsigned burst_left = 0;
  int unsigned bytes_sent = 0;
  int unsigned settings_used = 0;

  websocket_frame_deframer uut (
    .clk(clk),
    .rst(rst),
    .rx(rx_ch),
    .evt(evt_ch),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always #1 clk = ~clk;

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic longint unsigned at_most(longint unsigned a, longint unsigned b);
    return (a < b) ? a : b;
  endfunction

  // Mostly short frames, the odd one exactly at a limit of at most CTRL_MAX_LEN.
  function automatic int unsigned pick_len(longint unsigned limit);
    int unsigned r;
    r = $urandom_range(0, 9);
    if (limit == 0 || r == 0) return 0;
    if (r == 1 && limit <= CTRL_MAX_LEN) return int'(limit);
    return $urandom_range(1, int'(at_most(limit, 12)));
  endfunction

  task automatic send_byte(input logic [7:0] value);
    int unsigned gap;
    int unsigned r;
    gap = 0;
    r = $urandom_range(0, 99);
    if (burst_left != 0) burst_left--;
    else if (gaps_on) begin
      if (r == 0) burst_left = $urandom_range(20, 80);
      else if (r < 60) gap = 0;
      else if (r < 90) gap = $urandom_range(1, 3);
      else if (r < 98) gap = $urandom_range(4, 8);
      else gap = $urandom_range(15, 40);
    end
    if (gap != 0) begin
      rx_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    rx_ch.valid <= 1'b1;
    rx_ch.rx_byte <= value;
    @(posedge clk);
    while (!rx_ch.ready) @(posedge clk);
    sb.note_byte(value);
    bytes_sent++;
  endtask

  task automatic send_header(input logic fin, input logic [3:0] op, input logic [63:0] len);
    send_byte({fin, 3'b000, op});
    if (len <= CTRL_MAX_LEN) send_byte({1'b0, len[6:0]});
    else if (len <= 65535) begin
      send_byte(LEN16_MARK);
      send_byte(len[15:8]);
      send_byte(len[7:0]);
    end else begin
      send_byte(LEN64_MARK);
      for (int i = 7; i >= 0; i--) send_byte(len[8*i +: 8]);
    end
  endtask

  task automatic send_frame(input logic fin, input logic [3:0] op, input logic [63:0] len);
    send_header(fin, op, len);
    for (longint unsigned k = 0; k < len; k++) send_byte(rand_byte());
  endtask

  task automatic write_max_payload(input logic [MAXP_W-1:0] value);
    rx_ch.valid <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    sb.max_payload = value;
    settings_used++;
  endtask

  task automatic random_message();
    int unsigned r;
    int unsigned n;
    int unsigned len;
    longint unsigned budget;
    longint unsigned ctrl_lim;
    logic [3:0] op;
    r = $urandom_range(0, 19);
    op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    ctrl_lim = at_most(sb.max_payload, CTRL_MAX_LEN);
    if (r < 7) send_frame(1'b1, op, pick_len(sb.max_payload));
    else if (r < 11) begin
      budget = sb.max_payload;
      n = $urandom_range(2, 4);
      for (int i = 0; i < n; i++) begin
        len = pick_len(budget);
        budget -= len;
        send_frame(i == n - 1, (i == 0) ? op : OP_CONT, len);
        if (i < n - 1 && $urandom_range(0, 2) == 0)
          send_frame(1'b1, $urandom_range(0, 1) ? OP_PING : OP_PONG, pick_len(ctrl_lim));
      end
    end
    else if (r < 14) send_frame(1'b1, OP_PING, pick_len(ctrl_lim));
    else if (r < 16) send_frame(1'b1, OP_PONG, pick_len(ctrl_lim));
    else if (r < 18 && sb.max_payload >= LEN16_MARK)
      send_frame(1'b1, op, $urandom_range(126, int'(at_most(sb.max_payload, 400))));
    else if ($urandom_range(0, 1)) send_frame(1'b1, op, 0);
    else begin
      send_frame(1'b0, op, 0);
      send_frame(1'b1, OP_CONT, 0);
    end
  endtask

  task automatic run_closing(input closing_case_e which);
    logic [3:0] op;
    longint unsigned ctrl_lim;
    int unsigned half;
    op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    ctrl_lim = at_most(sb.max_payload, CTRL_MAX_LEN);
    case (which)
      END_RSV: begin
        send_byte({1'b1, 3'($urandom_range(1, 7)), op});
        send_byte(8'h00);
      end
      END_MASKED: begin
        send_byte({1'b1, 3'b000, op});
        send_byte({1'b1, 7'($urandom_range(0, 127))});
      end
      END_SHORT16: begin
        send_byte({1'b1, 3'b000, op});
        send_byte(LEN16_MARK);
        send_byte(8'h00);
        send_byte(8'($urandom_range(0, 125)));
      end
      END_LEN_MSB: begin
        send_byte({1'b1, 3'b000, op});
        send_byte(LEN64_MARK);
        send_byte(8'h80 | rand_byte());
        repeat (7) send_byte(rand_byte());
      end
      END_SHORT64: begin
        send_byte({1'b1, 3'b000, op});
        send_byte(LEN64_MARK);
        repeat (6) send_byte(8'h00);
        send_byte(rand_byte());
        send_byte(rand_byte());
      end
      END_TOO_BIG: send_header(1'b1, op, {33'd0, sb.max_payload} + 1);
      END_BAD_CTRL: begin
        case ($urandom_range(0, 2))
          0: op = OP_PING;
          1: op = OP_PONG;
          default: op = OP_CLOSE;
        endcase
        if ($urandom_range(0, 1)) send_header(1'b0, op, pick_len(ctrl_lim));
        else send_header(1'b1, op, $urandom_range(126, 135));
      end
      END_CLOSE_LEN1: send_header(1'b1, OP_CLOSE, 1);
      END_BAD_OP: begin
        op = 4'($urandom_range(3, 12));
        if (op >= OP_CLOSE) op = op + 4'd3;
        send_header(1'b1, op, pick_len(ctrl_lim));
      end
      END_DATA_FRAG: begin
        send_frame(1'b0, op, pick_len(sb.max_payload));
        send_header(1'b1, $urandom_range(0, 1) ? OP_TEXT : OP_BINARY, 0);
      end
      END_CONT_ALONE: send_header(1'b1, OP_CONT, pick_len(sb.max_payload));
      END_MSG_TOO_BIG: begin
        half = sb.max_payload / 2;
        send_frame(1'b0, op, half);
        send_header(1'b1, OP_CONT, sb.max_payload - half + 1);
      end
      END_CLOSE_PAYLOAD: send_frame(1'b1, OP_CLOSE, $urandom_range(2, int'(ctrl_lim)));
      END_CLOSE_EMPTY: send_header(1'b1, OP_CLOSE, 0);
      default: begin
        for (int i = 0; i < 200 && !sb.halted; i++) send_byte(rand_byte());
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (!rst && evt_ch.valid && evt_ch.ready)
      sb.check_result({evt_ch.kind, evt_ch.has_byte, evt_ch.payload_byte,
                       evt_ch.end_of_message, evt_ch.error_code});
  end

  // The long hold lets the sender keep offering until the block stops taking bytes.
  initial begin : receiver
    int unsigned span;
    evt_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_request = 1'b0;
        evt_ch.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else if ($urandom_range(0, 9) < 3) begin
        evt_ch.ready <= 1'b0;
        span = ($urandom_range(0, 19) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 3);
        repeat (span) @(posedge clk);
      end
      evt_ch.ready <= 1'b1;
      span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 150) : $urandom_range(1, 6);
      repeat (span - 1) @(posedge clk);
    end
  end

  initial begin : stimulus
    closing_case_e closing;
    int unsigned settings[4];
    int unsigned target;
    int unsigned drain_cycles;
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    rx_ch.valid <= 1'b0;
    rx_ch.rx_byte <= '0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_frame(1'b1, OP_TEXT, 0);
    send_header(1'b1, OP_BINARY, 2);
    send_byte(8'h00);
    send_byte(8'hFF);
    send_frame(1'b1, OP_TEXT, 1);
    send_frame(1'b1, OP_PING, 0);
    send_frame(1'b1, OP_PING, CTRL_MAX_LEN);
    send_frame(1'b1, OP_PONG, 0);
    send_frame(1'b1, OP_PONG, 7);
    send_frame(1'b1, OP_TEXT, 126);
    send_frame(1'b0, OP_TEXT, 2);
    send_frame(1'b1, OP_PING, 1);
    send_frame(1'b0, OP_CONT, 0);
    send_frame(1'b1, OP_PONG, 3);
    send_frame(1'b1, OP_CONT, 3);
    send_frame(1'b0, OP_BINARY, 0);
    send_frame(1'b1, OP_CONT, 0);

    settings = '{0, 32'h7FFF_FFFF, $urandom_range(126, 2000), $urandom_range(2, 400)};
    foreach (settings[i]) begin
      write_max_payload(settings[i][MAXP_W-1:0]);
      hold_request = 1'b1;
      target = bytes_sent + ITEMS_PER_SETTING;
      while (bytes_sent < target) random_message();
    end

    closing = closing_case_e'($urandom_range(0, END_NOISE));
    run_closing(closing);
    repeat (16) send_byte(rand_byte());
    rx_ch.valid <= 1'b0;

    drain_cycles = 0;
    while (sb.pending_results.size() != 0 && drain_cycles < 10000) begin
      @(posedge clk);
      drain_cycles++;
    end
    repeat (8) @(posedge clk);
    sb.drain_check();

    $display("Sent %0d bytes over %0d payload limits; %0d results checked", bytes_sent,
             settings_used + 1, sb.results_checked);
    $display("Results seen: text %0d, binary %0d, ping %0d, close %0d, error %0d; ended by %s",
             sb.kind_count[0], sb.kind_count[1], sb.kind_count[2], sb.kind_count[3],
             sb.kind_count[4], closing.name());
    if (sb.mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin : watchdog
    #20_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
